// ----- rtl/core/timer_event_deadline_queue_unit_defines.svh -----
// assertion macros for the timer event deadline queue
// no dependencies; included by files that carry concurrent assertions
`ifndef TIMER_EVENT_DEADLINE_QUEUE_UNIT_DEFINES_SVH
`define TIMER_EVENT_DEADLINE_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication under reset
`define TEDQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define TEDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/tedq_pkg.sv -----
// package of the timer event deadline queue: sizes, codes, entry type
// no dependencies
package tedq_pkg;

    localparam int DEPTH     = 16;
    localparam int TIME_BITS = 48;
    localparam int TAG_W     = 8;
    localparam int TYPE_W    = 3;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 20;
    localparam int MTL_W     = 5;
    localparam int LA_W      = 20;
    localparam int TPU_W     = 20;
    localparam int CMP_W     = 64;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int OCC_W     = $clog2(DEPTH + 1);
    localparam int LIM_W     = ((TIME_BITS > LA_W) ? TIME_BITS : LA_W) + 1;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

    localparam logic [KIND_W-1:0] RES_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] RES_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] RES_EVENT  = 2'd2;
    localparam logic [KIND_W-1:0] RES_DONE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TICK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS     = 2'd2;

    localparam logic [TYPE_W-1:0] TYPE_PARTITION = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_OTHER     = 3'd7;

    localparam logic [CMP_W-1:0] EMPTY_COMPARE = 64'hFFFF_FFFF_FFFF_FFFE;
    localparam logic [63:0] TIME_MASK64 = 64'((65'd1 << TIME_BITS) - 65'd1);

    typedef struct packed {
        logic [TIME_BITS-1:0] deadline;
        logic [TAG_W-1:0]     tag;
        logic [TYPE_W-1:0]    etype;
    } entry_t;

endpackage

// ----- rtl/core/tedq_if.sv -----
// channel interfaces of the timer event deadline queue
// depends on tedq_pkg
interface tedq_in_if;
    logic                            valid;
    logic                            ready;
    logic [tedq_pkg::KIND_W-1:0]     kind;
    logic [tedq_pkg::TAG_W-1:0]      event_tag;
    logic [tedq_pkg::TIME_BITS-1:0]  event_time;
    logic [tedq_pkg::TYPE_W-1:0]     event_type;

    modport source (output valid, kind, event_tag, event_time, event_type, input ready);
    modport sink (input valid, kind, event_tag, event_time, event_type, output ready);
endinterface

interface tedq_out_if;
    logic                          valid;
    logic                          ready;
    logic [tedq_pkg::KIND_W-1:0]   result_kind;
    logic [tedq_pkg::TAG_W-1:0]    out_tag;
    logic [tedq_pkg::TYPE_W-1:0]   out_type;
    logic [tedq_pkg::CMP_W-1:0]    compare_value;
    logic                          list_full;
    logic                          tag_missing;
    logic                          partition_due;
    logic                          process_woken;
    logic                          last;

    modport source (output valid, result_kind, out_tag, out_type, compare_value, list_full,
                    tag_missing, partition_due, process_woken, last, input ready);
    modport sink (input valid, result_kind, out_tag, out_type, compare_value, list_full,
                  tag_missing, partition_due, process_woken, last, output ready);
endinterface

interface tedq_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [tedq_pkg::CFG_IDX_W-1:0]   index;
    logic [tedq_pkg::CFG_DAT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/tedq_mult.sv -----
// comparator value unit: deadline times ticks_per_unit, saturated to 64 bits
// one shared multiplier over two half products; depends on tedq_pkg
module tedq_mult (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [tedq_pkg::TIME_BITS-1:0] deadline,
    input  logic [tedq_pkg::TPU_W-1:0]     tpu,
    output logic                           done,
    output logic [tedq_pkg::CMP_W-1:0]     value
);
    localparam int HALF  = tedq_pkg::TIME_BITS / 2;
    localparam int HIGHW = tedq_pkg::TIME_BITS - HALF;
    localparam int PW    = HIGHW + tedq_pkg::TPU_W;
    localparam int FULLW = tedq_pkg::TIME_BITS + tedq_pkg::TPU_W;

    logic [2:0]                       busy_reg;
    logic                             done_reg;
    logic [tedq_pkg::TIME_BITS-1:0]   dl_reg;
    logic [tedq_pkg::TPU_W-1:0]       tpu_reg;
    logic [PW-1:0]                    lo_reg;
    logic [PW-1:0]                    hi_reg;
    logic [tedq_pkg::CMP_W-1:0]       value_reg;
    logic [HIGHW-1:0]                 mul_a;
    logic [PW-1:0]                    prod;
    logic [FULLW-1:0]                 sum;
    logic [FULLW+63:0]                sum_ext;

    // high half on the second step, low half on the first
    assign mul_a = busy_reg[1] ? dl_reg[tedq_pkg::TIME_BITS-1:HALF]
                               : HIGHW'(dl_reg[HALF-1:0]);
    assign prod    = PW'(mul_a) * PW'(tpu_reg);
    assign sum     = FULLW'(lo_reg) + (FULLW'(hi_reg) << HALF);
    assign sum_ext = (FULLW + 64)'(sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= {busy_reg[1:0], start};
            done_reg <= busy_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dl_reg  <= deadline;
            tpu_reg <= tpu;
        end
        if (busy_reg[0])
            lo_reg <= prod;
        if (busy_reg[1])
            hi_reg <= prod;
        if (busy_reg[2])
            value_reg <= (|sum_ext[FULLW+63:64]) ? '1 : sum_ext[63:0];
    end

    assign done  = done_reg;
    assign value = value_reg;
endmodule

// ----- rtl/core/timer_event_deadline_queue_unit.sv -----
// top level of the timer event deadline queue: sorted event store and sequencer
// depends on tedq_pkg, tedq_if, tedq_mult and the defines header
//
//  channel | dir | handshake     | moves
//  --------+-----+---------------+-------------------------------------------
//  cmd     | in  | valid / ready | insert, remove or expire item
//  rsp     | out | valid / ready | one result per transfer, last on final one
//  cfg     | in  | valid / ready | register index and write data, always ready
//
// one item at a time; each entry visit is a store read followed by a check or a write
// insert and remove: scan the list, then shift the entries behind the position
// expire: scan and pop the due entries, compare, then one event result per popped entry
// the comparator steps are head read, start, two half products, sum, done
// reset empties the list at once; a stalled rsp holds the sequencer in place
`include "timer_event_deadline_queue_unit_defines.svh"

module timer_event_deadline_queue_unit (
    input  logic       clk,
    input  logic       rst_n,
    tedq_in_if.sink    cmd,
    tedq_out_if.source rsp,
    tedq_cfg_if.sink   cfg
);

    // sequencer states
    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_PREP     = 12'b0000_0000_0010,
        S_SCAN_RD  = 12'b0000_0000_0100,
        S_SCAN_CHK = 12'b0000_0000_1000,
        S_SHIFT_RD = 12'b0000_0001_0000,
        S_SHIFT_WR = 12'b0000_0010_0000,
        S_CMP_RD   = 12'b0000_0100_0000,
        S_MUL_GO   = 12'b0000_1000_0000,
        S_MUL_WAIT = 12'b0001_0000_0000,
        S_EMIT_RD  = 12'b0010_0000_0000,
        S_EMIT_WR  = 12'b0100_0000_0000,
        S_FINAL    = 12'b1000_0000_0000
    } state_t;

    localparam int OW = tedq_pkg::OCC_W;
    localparam int PW = tedq_pkg::PTR_W;
    localparam int TB = tedq_pkg::TIME_BITS;

    // circular index: logical slot off behind base, wrapped at the depth
    function automatic logic [PW-1:0] phys(input logic [PW-1:0] base,
                                           input logic [OW-1:0] off);
        logic [OW:0] s;
        s = (OW + 1)'(base) + (OW + 1)'(off);
        if (s >= (OW + 1)'(tedq_pkg::DEPTH))
            s = s - (OW + 1)'(tedq_pkg::DEPTH);
        return s[PW-1:0];
    endfunction

    state_t state_reg, state_next;

    // item latched at the transfer
    logic [tedq_pkg::KIND_W-1:0] kind_reg;
    logic [tedq_pkg::TAG_W-1:0]  tag_reg;
    logic [TB-1:0]               time_reg;
    logic [tedq_pkg::TYPE_W-1:0] type_reg;

    // configuration
    logic [tedq_pkg::MTL_W-1:0] mtl_reg;
    logic [tedq_pkg::LA_W-1:0]  la_reg;
    logic [tedq_pkg::TPU_W-1:0] tpu_reg;

    // list bookkeeping
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] old_head_reg, old_head_next;
    logic [OW-1:0] occ_reg, occ_next;
    logic [OW-1:0] idx_reg, idx_next;
    logic [OW-1:0] pos_reg, pos_next;
    logic [OW-1:0] pop_reg, pop_next;
    logic          found_reg, found_next;
    logic          full_reg, full_next;
    logic          part_reg, part_next;
    logic          proc_reg, proc_next;
    logic [tedq_pkg::TYPE_W-1:0] rtype_reg, rtype_next;
    logic [TB-1:0]               dl_reg, dl_next;
    logic [tedq_pkg::LIM_W-1:0]  limit_reg, limit_next;
    logic [tedq_pkg::CMP_W-1:0]  cmp_reg, cmp_next;

    // event store, one read and one write port, registered read data
    tedq_pkg::entry_t mem_q [tedq_pkg::DEPTH];
    tedq_pkg::entry_t rd_data_reg;
    logic             mem_re, mem_we;
    logic [PW-1:0]    mem_raddr, mem_waddr;
    tedq_pkg::entry_t mem_wdata;

    // output register
    logic                          out_vld_reg;
    logic                          out_load;
    logic                          slot_free;
    logic [tedq_pkg::KIND_W-1:0]   o_kind_reg, o_kind_next;
    logic [tedq_pkg::TAG_W-1:0]    o_tag_reg, o_tag_next;
    logic [tedq_pkg::TYPE_W-1:0]   o_type_reg, o_type_next;
    logic [tedq_pkg::CMP_W-1:0]    o_cmp_reg;
    logic                          o_full_reg, o_full_next;
    logic                          o_miss_reg, o_miss_next;
    logic                          o_part_reg, o_part_next;
    logic                          o_proc_reg, o_proc_next;
    logic                          o_last_reg, o_last_next;

    // comparator unit
    logic                         mul_start;
    logic                         mul_done;
    logic [tedq_pkg::CMP_W-1:0]   mul_value;

    // deadline rounding and expiry limit
    logic [63:0] low64, thr64, t64, up64;
    logic        cmd_take;
    logic        is_ins, is_rem, is_exp;

    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_take  = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;
    assign slot_free = !out_vld_reg || rsp.ready;

    assign is_ins = (kind_reg == tedq_pkg::KIND_INSERT);
    assign is_rem = (kind_reg == tedq_pkg::KIND_REMOVE);
    assign is_exp = (kind_reg == tedq_pkg::KIND_EXPIRE);

    // round up to the tick, saturating at the all-ones time
    assign low64 = (64'd1 << mtl_reg) - 64'd1;
    assign thr64 = tedq_pkg::TIME_MASK64 - low64;
    assign t64   = 64'(time_reg);
    assign up64  = (t64 + low64) & ~low64;

    tedq_mult u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mul_start),
        .deadline (rd_data_reg.deadline),
        .tpu      (tpu_reg),
        .done     (mul_done),
        .value    (mul_value)
    );

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        old_head_next = old_head_reg;
        occ_next      = occ_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        pop_next      = pop_reg;
        found_next    = found_reg;
        full_next     = full_reg;
        part_next     = part_reg;
        proc_next     = proc_reg;
        rtype_next    = rtype_reg;
        dl_next       = dl_reg;
        limit_next    = limit_reg;
        cmp_next      = cmp_reg;
        mem_re        = 1'b0;
        mem_raddr     = head_reg;
        mem_we        = 1'b0;
        mem_waddr     = head_reg;
        mem_wdata     = rd_data_reg;
        mul_start     = 1'b0;
        out_load      = 1'b0;
        o_kind_next   = tedq_pkg::RES_DONE;
        o_tag_next    = '0;
        o_type_next   = '0;
        o_full_next   = 1'b0;
        o_miss_next   = 1'b0;
        o_part_next   = 1'b0;
        o_proc_next   = 1'b0;
        o_last_next   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                // unknown kind is taken and dropped
                if (cmd_take && cmd.kind != tedq_pkg::KIND_NONE)
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                dl_next    = (t64 > thr64) ? tedq_pkg::TIME_MASK64[TB-1:0] : up64[TB-1:0];
                limit_next = tedq_pkg::LIM_W'(time_reg) + tedq_pkg::LIM_W'(la_reg);
                idx_next   = '0;
                found_next = 1'b0;
                rtype_next = '0;
                part_next  = 1'b0;
                proc_next  = 1'b0;
                full_next  = is_ins && (occ_reg == OW'(tedq_pkg::DEPTH));
                if (is_ins && (occ_reg == OW'(tedq_pkg::DEPTH)))
                    state_next = S_CMP_RD;
                else
                    state_next = S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                if (idx_reg == occ_reg)
                begin
                    // reached the tail without a stop
                    if (is_ins)
                    begin
                        pos_next   = occ_reg;
                        idx_next   = occ_reg;
                        state_next = S_SHIFT_RD;
                    end
                    else if (is_exp)
                    begin
                        pop_next      = idx_reg;
                        old_head_next = head_reg;
                        head_next     = phys(head_reg, idx_reg);
                        occ_next      = occ_reg - idx_reg;
                        state_next    = S_CMP_RD;
                    end
                    else
                        state_next = S_CMP_RD;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = phys(head_reg, idx_reg);
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                state_next = S_SCAN_RD;
                idx_next   = idx_reg + OW'(1);
                if (is_ins)
                begin
                    // insert goes behind equal deadlines
                    if (rd_data_reg.deadline > dl_reg)
                    begin
                        pos_next   = idx_reg;
                        idx_next   = occ_reg;
                        state_next = S_SHIFT_RD;
                    end
                end
                else if (is_rem)
                begin
                    if (rd_data_reg.tag == tag_reg)
                    begin
                        pos_next   = idx_reg;
                        idx_next   = idx_reg;
                        found_next = 1'b1;
                        rtype_next = rd_data_reg.etype;
                        state_next = S_SHIFT_RD;
                    end
                end
                else
                begin
                    if (tedq_pkg::LIM_W'(rd_data_reg.deadline) <= limit_reg)
                    begin
                        if (rd_data_reg.etype == tedq_pkg::TYPE_PARTITION)
                            part_next = 1'b1;
                        else if (rd_data_reg.etype != tedq_pkg::TYPE_OTHER)
                            proc_next = 1'b1;
                    end
                    else
                    begin
                        // popped entries stay in place behind the new head
                        pop_next      = idx_reg;
                        old_head_next = head_reg;
                        head_next     = phys(head_reg, idx_reg);
                        occ_next      = occ_reg - idx_reg;
                        idx_next      = idx_reg;
                        state_next    = S_CMP_RD;
                    end
                end
            end
            S_SHIFT_RD:
            begin
                if (is_ins)
                begin
                    if (idx_reg == pos_reg)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = phys(head_reg, pos_reg);
                        mem_wdata  = '{deadline: dl_reg, tag: tag_reg, etype: type_reg};
                        occ_next   = occ_reg + OW'(1);
                        state_next = S_CMP_RD;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = phys(head_reg, idx_reg - OW'(1));
                        state_next = S_SHIFT_WR;
                    end
                end
                else
                begin
                    if (OW'(idx_reg + OW'(1)) >= occ_reg)
                    begin
                        occ_next   = occ_reg - OW'(1);
                        state_next = S_CMP_RD;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = phys(head_reg, idx_reg + OW'(1));
                        state_next = S_SHIFT_WR;
                    end
                end
            end
            S_SHIFT_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = phys(head_reg, idx_reg);
                mem_wdata  = rd_data_reg;
                idx_next   = is_ins ? (idx_reg - OW'(1)) : (idx_reg + OW'(1));
                state_next = S_SHIFT_RD;
            end
            S_CMP_RD:
            begin
                if (occ_reg == '0)
                begin
                    cmp_next   = tedq_pkg::EMPTY_COMPARE;
                    idx_next   = '0;
                    state_next = is_exp ? S_EMIT_RD : S_FINAL;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = head_reg;
                    state_next = S_MUL_GO;
                end
            end
            S_MUL_GO:
            begin
                mul_start  = 1'b1;
                state_next = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    cmp_next   = mul_value;
                    idx_next   = '0;
                    state_next = is_exp ? S_EMIT_RD : S_FINAL;
                end
            end
            S_EMIT_RD:
            begin
                if (idx_reg == pop_reg)
                    state_next = S_FINAL;
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = phys(old_head_reg, idx_reg);
                    state_next = S_EMIT_WR;
                end
            end
            S_EMIT_WR:
            begin
                if (slot_free)
                begin
                    out_load    = 1'b1;
                    o_kind_next = tedq_pkg::RES_EVENT;
                    o_tag_next  = rd_data_reg.tag;
                    o_type_next = rd_data_reg.etype;
                    o_last_next = 1'b0;
                    idx_next    = idx_reg + OW'(1);
                    state_next  = S_EMIT_RD;
                end
            end
            S_FINAL:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    if (is_ins)
                    begin
                        o_kind_next = tedq_pkg::RES_INSERT;
                        o_tag_next  = tag_reg;
                        o_type_next = type_reg;
                        o_full_next = full_reg;
                    end
                    else if (is_rem)
                    begin
                        o_kind_next = tedq_pkg::RES_REMOVE;
                        o_tag_next  = tag_reg;
                        o_type_next = found_reg ? rtype_reg : '0;
                        o_miss_next = !found_reg;
                    end
                    else
                    begin
                        o_part_next = part_reg;
                        o_proc_next = proc_reg;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            occ_reg     <= '0;
            out_vld_reg <= 1'b0;
            mtl_reg     <= '0;
            la_reg      <= '0;
            tpu_reg     <= tedq_pkg::TPU_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            occ_reg   <= occ_next;
            if (out_load)
                out_vld_reg <= 1'b1;
            else if (rsp.ready)
                out_vld_reg <= 1'b0;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    tedq_pkg::CFG_MIN_TICK:  mtl_reg <= cfg.data[tedq_pkg::MTL_W-1:0];
                    tedq_pkg::CFG_LOOKAHEAD: la_reg  <= cfg.data[tedq_pkg::LA_W-1:0];
                    tedq_pkg::CFG_TICKS:     tpu_reg <= cfg.data[tedq_pkg::TPU_W-1:0];
                    default:                 ;
                endcase
            end
        end
    end

    // working registers and payload
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            kind_reg <= cmd.kind;
            tag_reg  <= cmd.event_tag;
            time_reg <= cmd.event_time;
            type_reg <= cmd.event_type;
        end
        old_head_reg <= old_head_next;
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        pop_reg      <= pop_next;
        found_reg    <= found_next;
        full_reg     <= full_next;
        part_reg     <= part_next;
        proc_reg     <= proc_next;
        rtype_reg    <= rtype_next;
        dl_reg       <= dl_next;
        limit_reg    <= limit_next;
        cmp_reg      <= cmp_next;
        if (out_load)
        begin
            o_kind_reg <= o_kind_next;
            o_tag_reg  <= o_tag_next;
            o_type_reg <= o_type_next;
            o_cmp_reg  <= cmp_reg;
            o_full_reg <= o_full_next;
            o_miss_reg <= o_miss_next;
            o_part_reg <= o_part_next;
            o_proc_reg <= o_proc_next;
            o_last_reg <= o_last_next;
        end
    end

    // event store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem_q[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem_q[mem_raddr];
    end

    assign rsp.valid         = out_vld_reg;
    assign rsp.result_kind   = o_kind_reg;
    assign rsp.out_tag       = o_tag_reg;
    assign rsp.out_type      = o_type_reg;
    assign rsp.compare_value = o_cmp_reg;
    assign rsp.list_full     = o_full_reg;
    assign rsp.tag_missing   = o_miss_reg;
    assign rsp.partition_due = o_part_reg;
    assign rsp.process_woken = o_proc_reg;
    assign rsp.last          = o_last_reg;

    // a waiting result is never overwritten
    `TEDQ_ASSERT_IMPLY(a_no_overwrite, clk, rst_n, (out_vld_reg && !rsp.ready), !out_load, "result overwritten while stalled")
    // expire never rewrites the store
    `TEDQ_ASSERT_IMPLY(a_expire_no_write, clk, rst_n, mem_we, (!is_exp && (state_reg == S_SHIFT_RD || state_reg == S_SHIFT_WR)), "store written outside a shift")
    // event results never run past the popped count
    `TEDQ_ASSERT_IMPLY(a_emit_bound, clk, rst_n, (state_reg == S_EMIT_WR), (idx_reg < pop_reg), "emitting beyond popped events")

endmodule

// ----- bench/tedq_scoreboard.sv -----
// checker for the timer event deadline queue: watches cmd, cfg and rsp transfers
// depends on tedq_pkg and tedq_if; predicts results and counts mismatches
module tedq_scoreboard (
    input  logic       clk,
    input  logic       rst_n,
    tedq_in_if.sink    cmd,
    tedq_out_if.sink   rsp,
    tedq_cfg_if.sink   cfg,
    output int         fail_count,
    output int         pending
);
    import tedq_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
        logic [TYPE_W-1:0] etype;
        logic [CMP_W-1:0]  cmp;
        logic              full;
        logic              missing;
        logic              part;
        logic              proc;
        logic              last;
    } result_t;

    entry_t      events [DEPTH];
    int          count;
    logic [4:0]  tick_log2;
    logic [19:0] lookahead;
    logic [19:0] ticks;
    result_t     expected_q [$];

    assign pending = expected_q.size();

    function automatic logic [TIME_BITS-1:0] align_deadline(logic [TIME_BITS-1:0] t);
        logic [64:0] low;
        logic [64:0] sum;
        low = (65'd1 << tick_log2) - 65'd1;
        sum = {17'd0, t} + low;
        if (sum > {1'b0, TIME_MASK64})
            return '1;
        return TIME_BITS'(sum & ~low);
    endfunction

    function automatic logic [CMP_W-1:0] comparator();
        logic [127:0] prod;
        if (count == 0)
            return EMPTY_COMPARE;
        prod = 128'(events[0].deadline) * 128'(ticks);
        if (prod[127:64] != 0)
            return '1;
        return prod[63:0];
    endfunction

    // apply one command to the model list and queue the results it causes
    task automatic predict_command(logic [KIND_W-1:0] k, logic [TAG_W-1:0] tg,
                                   logic [TIME_BITS-1:0] t, logic [TYPE_W-1:0] ty);
        result_t     batch [$];
        result_t     r;
        logic [TIME_BITS-1:0] d;
        logic [64:0] limit;
        int          pos;
        int          popped;
        logic        part;
        logic        proc;
        r = '0;
        part = 0;
        proc = 0;
        popped = 0;
        if (k == KIND_INSERT) begin
            r.kind = RES_INSERT; r.tag = tg; r.etype = ty; r.last = 1;
            if (count >= DEPTH)
                r.full = 1;
            else begin
                d = align_deadline(t);
                pos = count;
                for (int i = 0; i < count; i++)
                    if (events[i].deadline > d && pos == count) pos = i;
                for (int i = count; i > pos; i--) events[i] = events[i-1];
                events[pos] = '{deadline: d, tag: tg, etype: ty};
                count++;
            end
            batch.push_back(r);
        end else if (k == KIND_REMOVE) begin
            r.kind = RES_REMOVE; r.tag = tg; r.last = 1; r.missing = 1;
            pos = -1;
            for (int i = 0; i < count; i++)
                if (events[i].tag == tg && pos < 0) pos = i;
            if (pos >= 0) begin
                r.missing = 0;
                r.etype = events[pos].etype;
                for (int i = pos; i + 1 < count; i++) events[i] = events[i+1];
                count--;
            end
            batch.push_back(r);
        end else if (k == KIND_EXPIRE) begin
            limit = {17'd0, t} + {45'd0, lookahead};
            while (popped < count && {17'd0, events[popped].deadline} <= limit) begin
                r = '0;
                r.kind = RES_EVENT;
                r.tag = events[popped].tag;
                r.etype = events[popped].etype;
                if (events[popped].etype == TYPE_PARTITION) part = 1;
                else if (events[popped].etype != TYPE_OTHER) proc = 1;
                batch.push_back(r);
                popped++;
            end
            for (int i = 0; i + popped < count; i++) events[i] = events[i+popped];
            count -= popped;
            r = '0;
            r.kind = RES_DONE; r.part = part; r.proc = proc; r.last = 1;
            batch.push_back(r);
        end
        // comparator reflects the list after the whole command
        foreach (batch[i]) begin
            batch[i].cmp = comparator();
            expected_q.push_back(batch[i]);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t got;
        result_t exp_r;
        if (!rst_n) begin
            count      = 0;
            tick_log2  = 5'd0;
            lookahead  = 20'd0;
            ticks      = 20'd1;
            fail_count <= 0;
            expected_q.delete();
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    CFG_MIN_TICK:  tick_log2 = cfg.data[4:0];
                    CFG_LOOKAHEAD: lookahead = cfg.data;
                    CFG_TICKS:     ticks = cfg.data;
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready) begin
                got = '{rsp.result_kind, rsp.out_tag, rsp.out_type, rsp.compare_value,
                        rsp.list_full, rsp.tag_missing, rsp.partition_due,
                        rsp.process_woken, rsp.last};
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t: result mismatch, expected %h, actual %h",
                                 $time, exp_r, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cmd.valid && cmd.ready)
                predict_command(cmd.kind, cmd.event_tag, cmd.event_time, cmd.event_type);
        end
    end
endmodule

// ----- bench/timer_event_deadline_queue_unit_tb.sv -----
// testbench top of the timer event deadline queue: stimulus, idling and verdict
// depends on tedq_pkg, tedq_if, tedq_scoreboard and the block itself
module timer_event_deadline_queue_unit_tb;
    import tedq_pkg::*;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    bit   calm;           // no idling in the last part of the run
    bit   hold_rsp;       // long receiver stall request
    int   insert_tags[$]; // tags likely still in the list

    tedq_in_if  cmd ();
    tedq_out_if rsp ();
    tedq_cfg_if cfg ();

    timer_event_deadline_queue_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    tedq_scoreboard u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .rsp        (rsp),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // receiver: random stall bursts, or a long hold when asked
    initial
    begin
        int gap;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
                rsp.ready <= 1'b0;
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 17);
                rsp.ready <= 1'b0;
                repeat (gap) @(negedge clk);
                rsp.ready <= 1'b1;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // one command transfer, with a random idle burst ahead of it
    // valid stays up after the transfer until the next command or an idle
    task automatic send_command(logic [KIND_W-1:0] k, logic [TAG_W-1:0] tg,
                                logic [TIME_BITS-1:0] t, logic [TYPE_W-1:0] ty);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        cmd.valid      <= 1'b1;
        cmd.kind       <= k;
        cmd.event_tag  <= tg;
        cmd.event_time <= t;
        cmd.event_type <= ty;
        @(posedge clk);
        while (!cmd.ready) @(posedge clk);
        @(negedge clk);
        if (k == KIND_INSERT) insert_tags.push_back(tg);
    endtask

    // stop offering, wait for the queue to drain, then let the block settle
    task automatic drain();
        cmd.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    // random time, mostly clustered so that expires pop real events
    function automatic logic [TIME_BITS-1:0] rand_time();
        case ($urandom_range(0, 5))
            0: return TIME_BITS'({$urandom, $urandom});
            1: return '1 - TIME_BITS'($urandom_range(0, 300));
            default: return TIME_BITS'($urandom_range(0, 4000));
        endcase
    endfunction

    task automatic random_command();
        logic [TAG_W-1:0] tg;
        int sel;
        sel = $urandom_range(0, 19);
        tg  = TAG_W'($urandom);
        if (sel < 10)
            send_command(KIND_INSERT, tg, rand_time(), TYPE_W'($urandom));
        else if (sel < 14)
        begin
            if (insert_tags.size() != 0 && $urandom_range(0, 3) != 0)
                tg = TAG_W'(insert_tags[$urandom_range(0, insert_tags.size() - 1)]);
            send_command(KIND_REMOVE, tg, rand_time(), TYPE_W'($urandom));
        end
        else if (sel < 19)
            send_command(KIND_EXPIRE, tg, rand_time(), TYPE_W'($urandom));
        else
            send_command(KIND_NONE, tg, rand_time(), TYPE_W'($urandom));
    endtask

    initial
    begin
        calm      = 1'b0;
        hold_rsp  = 1'b0;
        cmd.valid = 1'b0;
        cmd.kind  = KIND_INSERT;
        cmd.event_tag  = '0;
        cmd.event_time = '0;
        cmd.event_type = '0;
        cfg.valid = 1'b0;
        cfg.index = CFG_MIN_TICK;
        cfg.data  = '0;
        rst_n     = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes of fields, every kind, full list, missing tag, duplicates
        send_command(KIND_EXPIRE, 8'h00, '0, 3'd0);
        send_command(KIND_INSERT, 8'hFF, '1, 3'd7);
        send_command(KIND_INSERT, 8'h00, '0, 3'd0);
        send_command(KIND_INSERT, 8'h5A, 48'd100, 3'd3);
        send_command(KIND_INSERT, 8'h5A, 48'd100, 3'd6);
        send_command(KIND_REMOVE, 8'h5A, '0, 3'd0);
        send_command(KIND_REMOVE, 8'h77, '0, 3'd0);
        send_command(KIND_NONE, 8'hAA, 48'hAAAA_AAAA_AAAA, 3'd5);
        for (int i = 0; i < 15; i++)
            send_command(KIND_INSERT, TAG_W'(i + 16), TIME_BITS'(i * 7), TYPE_W'(i));
        send_command(KIND_EXPIRE, 8'h00, 48'd50, 3'd0);
        send_command(KIND_EXPIRE, 8'h00, '1, 3'd0);
        drain();

        // large alignment, saturating lookahead and comparator overflow
        write_reg(CFG_MIN_TICK, 20'd20);
        write_reg(CFG_LOOKAHEAD, 20'hFFFFF);
        write_reg(CFG_TICKS, 20'hFFFFF);
        send_command(KIND_INSERT, 8'h11, '1 - 48'd5, 3'd1);
        send_command(KIND_INSERT, 8'h12, 48'd1, 3'd0);
        send_command(KIND_EXPIRE, 8'h00, '1, 3'd0);
        for (int i = 0; i < 20; i++) random_command();
        drain();

        // zero ticks per unit
        write_reg(CFG_TICKS, 20'd0);
        write_reg(CFG_MIN_TICK, 20'd3);
        write_reg(CFG_LOOKAHEAD, 20'd500);
        for (int i = 0; i < 20; i++) random_command();

        // sender pauses until everything is back
        drain();

        // long receiver stall while commands keep coming, list fills up
        write_reg(CFG_TICKS, 20'd1000);
        write_reg(CFG_MIN_TICK, 20'd0);
        write_reg(CFG_LOOKAHEAD, 20'd0);
        fork
            begin
                hold_rsp = 1'b1;
                repeat (400) @(negedge clk);
                hold_rsp = 1'b0;
            end
            for (int i = 0; i < 20; i++)
                send_command(KIND_INSERT, TAG_W'($urandom), rand_time(), TYPE_W'($urandom));
        join
        for (int i = 0; i < 50; i++) random_command();
        drain();

        write_reg(CFG_TICKS, 20'd1);
        write_reg(CFG_MIN_TICK, CFG_DAT_W'($urandom_range(0, 6)));
        write_reg(CFG_LOOKAHEAD, 20'd100);
        calm = 1'b1;
        for (int i = 0; i < 40; i++) random_command();
        send_command(KIND_EXPIRE, 8'h00, '1, 3'd0);

        drain();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
